FILE: design/fgiq_pkg.sv
package fgiq_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH          = 3'd0,
    CMD_REMOVE_IMAGE  = 3'd1,
    CMD_POP_READY     = 3'd2,
    CMD_MARK_FENCE    = 3'd3,
    CMD_REMOVE_OLDEST = 3'd4
  } cmd_e;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_BUSY = 2'd2;

  typedef struct packed {
    logic        pending;
    logic [15:0] fence;
    logic [15:0] image;
  } entry_t;

endpackage

FILE: design/fgiq_ram.sv
module fgiq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: design/fence_gated_image_queue.sv
// Push and remove-oldest go straight to the done state, which registers the result once the output is free.
// Remove-image, pop and mark walk the held entries through the entry RAM, one
// read per cycle; pop stops at the first entry that is no longer pending.
// One command is worked on at a time; the next word is taken once the result
// is registered, even while that result still waits on the output side.
// Reset empties the queue and the output register; entry contents need no clear.
module fence_gated_image_queue
  import fgiq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // image_id[15:0], has_fence[16], fence_id[32:17], fence_busy[33],
  // wait_start_failed[34], remove_count[39:35]
  input  logic [39:0] s_axis_tdata_i,
  // command[2:0]
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status[1:0], image_valid[2], image_out[18:3], any_ready[19],
  // occupancy[24:20], zero[31:25]
  output logic [31:0] m_axis_tdata_o
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = ((CW > IW) ? CW : IW) + 1;
  localparam int MW = (CW > 5) ? CW : 5;
  localparam int EW = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e          state_q, state_d;
  logic [IW-1:0]   head_q, head_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   k_q, k_d;
  logic [CW-1:0]   w_q, w_d;
  logic [CW-1:0]   ridx_q, ridx_d;
  logic            rvld_q, rvld_d;
  logic            found_q, found_d;
  logic [CW-1:0]   fidx_q, fidx_d;
  logic [15:0]     fimg_q, fimg_d;
  logic            any_q, any_d;
  cmd_e            cmd_q, cmd_d;
  logic [15:0]     img_q, img_d;
  logic            hasf_q, hasf_d;
  logic [15:0]     fence_q, fence_d;
  logic            busy_q, busy_d;
  logic            wfail_q, wfail_d;
  logic [4:0]      rcnt_q, rcnt_d;
  logic            ovld_q, ovld_d;
  logic [31:0]     odata_q, odata_d;

  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  entry_t          ram_wdata;
  logic [IW-1:0]   ram_raddr;
  logic [EW-1:0]   ram_rdata;
  entry_t          rd_entry;

  logic            issue;
  logic            hit_now;
  logic [CW-1:0]   logical;
  logic [MW-1:0]   drop_n;
  logic [1:0]      res_status;
  logic            res_valid;
  logic [15:0]     res_image;
  logic            res_any;
  logic            out_free;

  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                            input logic [CW-1:0] idx);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(idx);
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  fgiq_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_entry        = entry_t'(ram_rdata);
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = odata_q;
  assign out_free        = !ovld_q || m_axis_tready_i;

  assign logical = (cmd_q == CMD_POP_READY) ? (cnt_q - CW'(1) - k_q) : k_q;
  assign hit_now = rvld_q && !found_q && !rd_entry.pending && (cmd_q == CMD_POP_READY);
  assign issue   = (k_q < cnt_q) && !((cmd_q == CMD_POP_READY) && (found_q || hit_now));
  assign ram_raddr = slot_of(head_q, logical);
  assign drop_n  = (MW'(rcnt_q) > MW'(cnt_q)) ? MW'(cnt_q) : MW'(rcnt_q);

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    w_d     = w_q;
    ridx_d  = ridx_q;
    rvld_d  = 1'b0;
    found_d = found_q;
    fidx_d  = fidx_q;
    fimg_d  = fimg_q;
    any_d   = any_q;
    cmd_d   = cmd_q;
    img_d   = img_q;
    hasf_d  = hasf_q;
    fence_d = fence_q;
    busy_d  = busy_q;
    wfail_d = wfail_q;
    rcnt_d  = rcnt_q;
    ovld_d  = ovld_q && !m_axis_tready_i;
    odata_d = odata_q;
    ram_we    = 1'b0;
    ram_waddr = slot_of(head_q, ridx_q);
    ram_wdata = rd_entry;
    res_status = STATUS_OK;
    res_valid  = 1'b0;
    res_image  = '0;
    res_any    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_d   = cmd_e'(s_axis_tuser_i);
          img_d   = s_axis_tdata_i[15:0];
          hasf_d  = s_axis_tdata_i[16];
          fence_d = s_axis_tdata_i[32:17];
          busy_d  = s_axis_tdata_i[33];
          wfail_d = s_axis_tdata_i[34];
          rcnt_d  = s_axis_tdata_i[39:35];
          k_d     = '0;
          w_d     = '0;
          found_d = 1'b0;
          any_d   = 1'b0;
          if ((cmd_e'(s_axis_tuser_i) == CMD_REMOVE_IMAGE) ||
              (cmd_e'(s_axis_tuser_i) == CMD_POP_READY) ||
              (cmd_e'(s_axis_tuser_i) == CMD_MARK_FENCE)) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rvld_d = 1'b1;
          ridx_d = logical;
          k_d    = k_q + CW'(1);
        end
        if (rvld_q) begin
          case (cmd_q)
            CMD_REMOVE_IMAGE: begin
              if (rd_entry.image != img_q) begin
                if (w_q != ridx_q) begin
                  ram_we    = 1'b1;
                  ram_waddr = slot_of(head_q, w_q);
                end
                w_d = w_q + CW'(1);
              end
            end
            CMD_POP_READY: begin
              if (hit_now) begin
                found_d = 1'b1;
                fidx_d  = ridx_q;
                fimg_d  = rd_entry.image;
              end
            end
            CMD_MARK_FENCE: begin
              if (rd_entry.pending && (rd_entry.fence == fence_q)) begin
                ram_we            = 1'b1;
                ram_wdata.pending = 1'b0;
                any_d             = 1'b1;
              end else if (!rd_entry.pending) begin
                any_d = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        if (!issue && !rvld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          case (cmd_q)
            CMD_PUSH: begin
              if (cnt_q >= CW'(QUEUE_DEPTH)) begin
                res_status = STATUS_FULL;
              end else if (hasf_q && busy_q) begin
                res_status = STATUS_BUSY;
              end else begin
                ram_we            = 1'b1;
                ram_waddr         = slot_of(head_q, cnt_q);
                ram_wdata.image   = img_q;
                ram_wdata.fence   = fence_q;
                ram_wdata.pending = hasf_q && !wfail_q;
                cnt_d             = cnt_q + CW'(1);
              end
            end
            CMD_REMOVE_IMAGE: begin
              cnt_d = w_q;
            end
            CMD_POP_READY: begin
              if (found_q) begin
                res_valid = 1'b1;
                res_image = fimg_q;
                head_d    = slot_of(head_q, fidx_q + CW'(1));
                cnt_d     = cnt_q - (fidx_q + CW'(1));
              end
            end
            CMD_MARK_FENCE: begin
              res_any = any_q;
            end
            CMD_REMOVE_OLDEST: begin
              head_d = slot_of(head_q, drop_n[CW-1:0]);
              cnt_d  = cnt_q - drop_n[CW-1:0];
            end
            default: begin
            end
          endcase
          ovld_d  = 1'b1;
          odata_d = {7'd0, 5'(MW'(cnt_d)), res_any, res_image, res_valid, res_status};
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      k_q     <= '0;
      w_q     <= '0;
      ridx_q  <= '0;
      rvld_q  <= 1'b0;
      found_q <= 1'b0;
      fidx_q  <= '0;
      fimg_q  <= '0;
      any_q   <= 1'b0;
      cmd_q   <= CMD_PUSH;
      img_q   <= '0;
      hasf_q  <= 1'b0;
      fence_q <= '0;
      busy_q  <= 1'b0;
      wfail_q <= 1'b0;
      rcnt_q  <= '0;
      ovld_q  <= 1'b0;
      odata_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      w_q     <= w_d;
      ridx_q  <= ridx_d;
      rvld_q  <= rvld_d;
      found_q <= found_d;
      fidx_q  <= fidx_d;
      fimg_q  <= fimg_d;
      any_q   <= any_d;
      cmd_q   <= cmd_d;
      img_q   <= img_d;
      hasf_q  <= hasf_d;
      fence_q <= fence_d;
      busy_q  <= busy_d;
      wfail_q <= wfail_d;
      rcnt_q  <= rcnt_d;
      ovld_q  <= ovld_d;
      odata_q <= odata_d;
    end
  end

endmodule
